FILE: design/rmq_pkg.sv
// Shared widths, limits and branch codes for the rotation matrix to quaternion pipeline.
// No dependencies; used by rmq_sqrt, rmq_div and the top level.
package rmq_pkg;

    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DEN_W  = 33;
    localparam int QUO_W  = 31;

    localparam logic [QUO_W-1:0] INTER_MAX = '1;

    typedef logic [1:0] t_branch;

    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_ROW0  = 2'd1;
    localparam t_branch BR_ROW1  = 2'd2;
    localparam t_branch BR_ROW2  = 2'd3;

endpackage

FILE: design/rmq_sqrt.sv
// Pipelined integer square root: floor(sqrt(x)) of a 64-bit word, one root bit per stage.
// Depends on rmq_pkg for widths. A side word of PW bits travels alongside.
module rmq_sqrt #(
    parameter int PW = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [rmq_pkg::RAD_W-1:0] i_rad,
    input  logic [PW-1:0]             i_side,
    output logic                      o_valid,
    output logic [rmq_pkg::ROOT_W-1:0] o_root,
    output logic [PW-1:0]             o_side
);

    localparam int NS = rmq_pkg::ROOT_W;
    localparam int RW = rmq_pkg::RAD_W;

    logic          a_valid [NS];
    logic [RW-1:0] a_v     [NS];
    logic [RW-1:0] a_r     [NS];
    logic [PW-1:0] a_side  [NS];

    logic          r_valid [NS];
    logic [RW-1:0] r_v     [NS];
    logic [RW-1:0] r_r     [NS];
    logic [PW-1:0] r_side  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);

        logic [RW-1:0] trial;
        logic [RW-1:0] n_v;
        logic [RW-1:0] n_r;

        if (k == 0) begin : g_first
            assign a_valid[k] = i_valid;
            assign a_v[k]     = i_rad;
            assign a_r[k]     = '0;
            assign a_side[k]  = i_side;
        end else begin : g_next
            assign a_valid[k] = r_valid[k-1];
            assign a_v[k]     = r_v[k-1];
            assign a_r[k]     = r_r[k-1];
            assign a_side[k]  = r_side[k-1];
        end

        always_comb begin
            trial = a_r[k] + BIT;
            if (a_v[k] >= trial) begin
                n_v = a_v[k] - trial;
                n_r = (a_r[k] >> 1) + BIT;
            end else begin
                n_v = a_v[k];
                n_r = a_r[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= a_valid[k];
            end
            r_v[k]    <= n_v;
            r_r[k]    <= n_r;
            r_side[k] <= a_side[k];
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_root  = r_r[NS-1][rmq_pkg::ROOT_W-1:0];
    assign o_side  = r_side[NS-1];

`ifndef SYNTHESIS
    // The remainder of a floor square root never exceeds twice the root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[NS-1] |-> (r_v[NS-1] <= (r_r[NS-1] << 1)))
        else $error("square root remainder out of range");
`endif

endmodule

FILE: design/rmq_div.sv
// Pipelined restoring divider, NL lanes sharing one divisor, one quotient bit per stage.
// Depends on rmq_pkg. Quotients that do not fit QUO_W bits saturate to all ones.
module rmq_div #(
    parameter int NL = 4,
    parameter int PW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [rmq_pkg::RAD_W-1:0]  i_num [NL],
    input  logic [rmq_pkg::DEN_W-1:0]  i_den,
    input  logic [PW-1:0]              i_side,
    output logic                       o_valid,
    output logic [rmq_pkg::QUO_W-1:0]  o_quo [NL],
    output logic [PW-1:0]              o_side
);

    localparam int NS = rmq_pkg::QUO_W;
    localparam int NW = rmq_pkg::RAD_W;
    localparam int DW = rmq_pkg::DEN_W;

    logic          a_valid [NS];
    logic [NW-1:0] a_rem   [NS][NL];
    logic [NS-1:0] a_quo   [NS][NL];
    logic          a_ovf   [NS][NL];
    logic [DW-1:0] a_den   [NS];
    logic [PW-1:0] a_side  [NS];

    logic          r_valid [NS];
    logic [NW-1:0] r_rem   [NS][NL];
    logic [NS-1:0] r_quo   [NS][NL];
    logic          r_ovf   [NS][NL];
    logic [DW-1:0] r_den   [NS];
    logic [PW-1:0] r_side  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int S = NS - 1 - k;

        logic [NW-1:0] dsh;
        logic [NW-1:0] n_rem [NL];
        logic [NS-1:0] n_quo [NL];

        if (k == 0) begin : g_first
            // A dividend at or above the divisor shifted by the quotient width overflows.
            for (genvar l = 0; l < NL; l++) begin : g_lane
                assign a_rem[k][l] = i_num[l];
                assign a_quo[k][l] = '0;
                assign a_ovf[k][l] = {1'b0, i_num[l]}
                    >= ({{(NW + 1 - DW){1'b0}}, i_den} << NS);
            end
            assign a_valid[k] = i_valid;
            assign a_den[k]   = i_den;
            assign a_side[k]  = i_side;
        end else begin : g_next
            for (genvar l = 0; l < NL; l++) begin : g_lane
                assign a_rem[k][l] = r_rem[k-1][l];
                assign a_quo[k][l] = r_quo[k-1][l];
                assign a_ovf[k][l] = r_ovf[k-1][l];
            end
            assign a_valid[k] = r_valid[k-1];
            assign a_den[k]   = r_den[k-1];
            assign a_side[k]  = r_side[k-1];
        end

        always_comb begin
            dsh = {{(NW - DW){1'b0}}, a_den[k]} << S;
            for (int l = 0; l < NL; l++) begin
                n_rem[l] = a_rem[k][l];
                n_quo[l] = a_quo[k][l];
                if (a_rem[k][l] >= dsh) begin
                    n_rem[l]    = a_rem[k][l] - dsh;
                    n_quo[l][S] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= a_valid[k];
            end
            for (int l = 0; l < NL; l++) begin
                r_rem[k][l] <= n_rem[l];
                r_quo[k][l] <= n_quo[l];
                r_ovf[k][l] <= a_ovf[k][l];
            end
            r_den[k]  <= a_den[k];
            r_side[k] <= a_side[k];
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_out
        assign o_quo[l] = r_ovf[NS-1][l] ? rmq_pkg::INTER_MAX : r_quo[NS-1][l];
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];

`ifndef SYNTHESIS
    // Without overflow the final remainder of lane 0 is below the divisor.
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NS-1] && !r_ovf[NS-1][0])
            |-> (r_rem[NS-1][0] < {{(NW - DW){1'b0}}, r_den[NS-1]}))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: design/rotation_matrix_to_quaternion_top.sv
// Top level: rotation matrix (Q1.30) to unit quaternion by the usual four-branch method.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//  channel   direction  handshake            words
//  matrix    in         start, busy          i_r00 .. i_r22
//  result    out        o_done (strobe)      o_qw, o_qx, o_qy, o_qz, o_branch, o_norm_failed
//
// One matrix is taken in every cycle while busy is low; its result strobes on o_done.
// Latency is set mostly by the two square roots (32 stages each, one root bit per stage)
// and the two dividers (31 stages each, one quotient bit per stage).
// busy is high only while reset is asserted; reset clears the valid bits alone.
// The receiver cannot stall, so the pipeline never holds and nothing waits inside.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_r00,
    input  logic signed [31:0] i_r01,
    input  logic signed [31:0] i_r02,
    input  logic signed [31:0] i_r10,
    input  logic signed [31:0] i_r11,
    input  logic signed [31:0] i_r12,
    input  logic signed [31:0] i_r20,
    input  logic signed [31:0] i_r21,
    input  logic signed [31:0] i_r22,
    output logic               o_done,
    output logic signed [31:0] o_qw,
    output logic signed [31:0] o_qx,
    output logic signed [31:0] o_qy,
    output logic signed [31:0] o_qz,
    output logic [1:0]         o_branch,
    output logic               o_norm_failed
);

    localparam int QW = rmq_pkg::QUO_W;
    localparam int RW = rmq_pkg::RAD_W;

    localparam logic signed [35:0] ONE_A = 36'sd1 <<< FRAC_BITS;
    localparam logic [QW-1:0]      ONE_Q = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [31:0] ONE_O = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        rmq_pkg::t_branch br;
        logic [3:0][32:0] num;
    } t_side_a;

    typedef struct packed {
        rmq_pkg::t_branch br;
        logic [QW-1:0]    lead;
        logic             zero;
        logic [3:0]       neg;
        logic [3:0]       nz;
    } t_side_b;

    typedef struct packed {
        rmq_pkg::t_branch     br;
        logic [3:0]           neg;
        logic [3:0][QW-1:0]   mag;
        logic                 fail;
    } t_side_c;

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // Stage 1: capture the matrix, form the trace and the diagonal comparisons.
    logic               r1_valid;
    logic signed [31:0] r1_m [9];
    logic signed [33:0] r1_trace;
    logic               r1_g0;
    logic               r1_g1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_m[0]  <= i_r00;
        r1_m[1]  <= i_r01;
        r1_m[2]  <= i_r02;
        r1_m[3]  <= i_r10;
        r1_m[4]  <= i_r11;
        r1_m[5]  <= i_r12;
        r1_m[6]  <= i_r20;
        r1_m[7]  <= i_r21;
        r1_m[8]  <= i_r22;
        r1_trace <= 34'(i_r00) + 34'(i_r11) + 34'(i_r22);
        r1_g0    <= (i_r00 > i_r11) && (i_r00 > i_r22);
        r1_g1    <= i_r11 > i_r22;
    end

    // Stage 2: pick the branch, form the radicand and the off-diagonal numerators.
    rmq_pkg::t_branch   n2_br;
    logic signed [35:0] n2_arg;
    logic signed [32:0] n2_num [4];
    logic signed [35:0] d0, d1, d2;

    logic               r2_valid;
    logic [RW-1:0]      r2_rad;
    t_side_a            r2_side;

    always_comb begin
        d0 = 36'(r1_m[0]);
        d1 = 36'(r1_m[4]);
        d2 = 36'(r1_m[8]);
        if (r1_trace > 34'sd0) begin
            n2_br = rmq_pkg::BR_TRACE;
        end else if (r1_g0) begin
            n2_br = rmq_pkg::BR_ROW0;
        end else if (r1_g1) begin
            n2_br = rmq_pkg::BR_ROW1;
        end else begin
            n2_br = rmq_pkg::BR_ROW2;
        end
        for (int i = 0; i < 4; i++) begin
            n2_num[i] = '0;
        end
        unique case (n2_br)
            rmq_pkg::BR_TRACE: begin
                n2_arg    = 36'(r1_trace) + ONE_A;
                n2_num[1] = 33'(r1_m[7]) - 33'(r1_m[5]);
                n2_num[2] = 33'(r1_m[2]) - 33'(r1_m[6]);
                n2_num[3] = 33'(r1_m[3]) - 33'(r1_m[1]);
            end
            rmq_pkg::BR_ROW0: begin
                n2_arg    = ONE_A + d0 - d1 - d2;
                n2_num[0] = 33'(r1_m[7]) - 33'(r1_m[5]);
                n2_num[2] = 33'(r1_m[1]) + 33'(r1_m[3]);
                n2_num[3] = 33'(r1_m[2]) + 33'(r1_m[6]);
            end
            rmq_pkg::BR_ROW1: begin
                n2_arg    = ONE_A + d1 - d0 - d2;
                n2_num[0] = 33'(r1_m[2]) - 33'(r1_m[6]);
                n2_num[1] = 33'(r1_m[1]) + 33'(r1_m[3]);
                n2_num[3] = 33'(r1_m[5]) + 33'(r1_m[7]);
            end
            default: begin
                n2_arg    = ONE_A + d2 - d0 - d1;
                n2_num[0] = 33'(r1_m[3]) - 33'(r1_m[1]);
                n2_num[1] = 33'(r1_m[2]) + 33'(r1_m[6]);
                n2_num[2] = 33'(r1_m[5]) + 33'(r1_m[7]);
            end
        endcase
        // A matrix that is not a rotation can give a negative radicand; it counts as zero.
        if (n2_arg < 36'sd0) begin
            n2_arg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_rad     <= {{(RW - 33){1'b0}}, n2_arg[32:0]} << FRAC_BITS;
        r2_side.br <= n2_br;
        for (int i = 0; i < 4; i++) begin
            r2_side.num[i] <= n2_num[i];
        end
    end

    logic                       sa_valid;
    logic [rmq_pkg::ROOT_W-1:0] sa_root;
    t_side_a                    sa_side;

    rmq_sqrt #(
        .PW ($bits(t_side_a))
    ) u_sqrt_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_rad   (r2_rad),
        .i_side  (r2_side),
        .o_valid (sa_valid),
        .o_root  (sa_root),
        .o_side  (sa_side)
    );

    // Stage G: leading component, and dividends rounded by half the divisor.
    logic [32:0] g_lead_w;
    logic [32:0] g_mag [4];
    logic        rg_valid;
    logic [RW-1:0] rg_num [4];
    logic [rmq_pkg::DEN_W-1:0] rg_den;
    t_side_b     rg_side;

    always_comb begin
        g_lead_w = (33'(sa_root) + 33'd1) >> 1;
        for (int i = 0; i < 4; i++) begin
            g_mag[i] = sa_side.num[i][32] ? (33'd0 - sa_side.num[i]) : sa_side.num[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg_valid <= 1'b0;
        end else begin
            rg_valid <= sa_valid;
        end
        for (int i = 0; i < 4; i++) begin
            rg_num[i]      <= ({{(RW - 33){1'b0}}, g_mag[i]} << FRAC_BITS)
                              + {{(RW - rmq_pkg::ROOT_W){1'b0}}, sa_root};
            rg_side.neg[i] <= sa_side.num[i][32];
            rg_side.nz[i]  <= sa_side.num[i] != '0;
        end
        rg_den       <= {sa_root, 1'b0};
        rg_side.br   <= sa_side.br;
        rg_side.zero <= sa_root == '0;
        rg_side.lead <= (g_lead_w[32:QW] != '0) ? rmq_pkg::INTER_MAX : g_lead_w[QW-1:0];
    end

    logic          da_valid;
    logic [QW-1:0] da_quo [4];
    t_side_b       da_side;

    rmq_div #(
        .NL (4),
        .PW ($bits(t_side_b))
    ) u_div_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rg_valid),
        .i_num   (rg_num),
        .i_den   (rg_den),
        .i_side  (rg_side),
        .o_valid (da_valid),
        .o_quo   (da_quo),
        .o_side  (da_side)
    );

    // Stage H: assemble the intermediate quaternion as sign and magnitude.
    logic    rh_valid;
    t_side_c rh_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rh_valid <= 1'b0;
        end else begin
            rh_valid <= da_valid;
        end
        rh_side.br   <= da_side.br;
        rh_side.fail <= 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (da_side.br == 2'(i)) begin
                rh_side.mag[i] <= da_side.lead;
                rh_side.neg[i] <= 1'b0;
            end else if (da_side.zero) begin
                // A zero root saturates each quotient of a nonzero numerator, with its sign; zero stays zero.
                rh_side.mag[i] <= da_side.nz[i] ? rmq_pkg::INTER_MAX : '0;
                rh_side.neg[i] <= da_side.neg[i];
            end else begin
                rh_side.mag[i] <= da_quo[i];
                rh_side.neg[i] <= da_side.neg[i];
            end
        end
    end

    // Stages Q, S and N: squares and their sum; the norm is zero only if all parts are.
    logic [2*QW-1:0] rq_sq [4];
    logic            rq_valid;
    t_side_c         rq_side;
    logic [2*QW:0]   rs_sum [2];
    logic            rs_valid;
    t_side_c         rs_side;
    logic [RW-1:0]   rn_norm2;
    logic            rn_valid;
    t_side_c         rn_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_valid <= 1'b0;
            rs_valid <= 1'b0;
            rn_valid <= 1'b0;
        end else begin
            rq_valid <= rh_valid;
            rs_valid <= rq_valid;
            rn_valid <= rs_valid;
        end
        for (int i = 0; i < 4; i++) begin
            rq_sq[i] <= {{QW{1'b0}}, rh_side.mag[i]} * {{QW{1'b0}}, rh_side.mag[i]};
        end
        rq_side.br   <= rh_side.br;
        rq_side.neg  <= rh_side.neg;
        rq_side.mag  <= rh_side.mag;
        rq_side.fail <= rh_side.mag == '0;
        rs_sum[0]    <= {1'b0, rq_sq[0]} + {1'b0, rq_sq[1]};
        rs_sum[1]    <= {1'b0, rq_sq[2]} + {1'b0, rq_sq[3]};
        rs_side      <= rq_side;
        rn_norm2     <= {{(RW - 2*QW - 1){1'b0}}, rs_sum[0]}
                        + {{(RW - 2*QW - 1){1'b0}}, rs_sum[1]};
        rn_side      <= rs_side;
    end

    logic                       sb_valid;
    logic [rmq_pkg::ROOT_W-1:0] sb_norm;
    t_side_c                    sb_side;

    rmq_sqrt #(
        .PW ($bits(t_side_c))
    ) u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rn_valid),
        .i_rad   (rn_norm2),
        .i_side  (rn_side),
        .o_valid (sb_valid),
        .o_root  (sb_norm),
        .o_side  (sb_side)
    );

    // Stage J: normalisation dividends.
    logic                      rj_valid;
    logic [RW-1:0]             rj_num [4];
    logic [rmq_pkg::DEN_W-1:0] rj_den;
    t_side_c                   rj_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rj_valid <= 1'b0;
        end else begin
            rj_valid <= sb_valid;
        end
        for (int i = 0; i < 4; i++) begin
            rj_num[i] <= ({{(RW - QW){1'b0}}, sb_side.mag[i]} << FRAC_BITS)
                         + {{(RW - rmq_pkg::ROOT_W + 1){1'b0}}, sb_norm[rmq_pkg::ROOT_W-1:1]};
        end
        rj_den  <= {1'b0, sb_norm};
        rj_side <= sb_side;
    end

    logic          db_valid;
    logic [QW-1:0] db_quo [4];
    t_side_c       db_side;

    rmq_div #(
        .NL (4),
        .PW ($bits(t_side_c))
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rj_valid),
        .i_num   (rj_num),
        .i_den   (rj_den),
        .i_side  (rj_side),
        .o_valid (db_valid),
        .o_quo   (db_quo),
        .o_side  (db_side)
    );

    // Stage K: saturate to plus or minus one and restore the sign.
    logic [QW-1:0]      k_val [4];
    logic signed [31:0] k_out [4];
    logic               r_done;
    logic signed [31:0] r_q [4];
    logic [1:0]         r_branch;
    logic               r_fail;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            k_val[i] = db_side.fail ? db_side.mag[i] : db_quo[i];
            if (k_val[i] > ONE_Q) begin
                k_val[i] = ONE_Q;
            end
            k_out[i] = db_side.neg[i] ? (32'sd0 - $signed({1'b0, k_val[i]}))
                                      : $signed({1'b0, k_val[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= db_valid;
        end
        for (int i = 0; i < 4; i++) begin
            r_q[i] <= k_out[i];
        end
        r_branch <= db_side.br;
        r_fail   <= db_side.fail;
    end

    assign o_done        = r_done;
    assign o_qw          = r_q[0];
    assign o_qx          = r_q[1];
    assign o_qy          = r_q[2];
    assign o_qz          = r_q[3];
    assign o_branch      = r_branch;
    assign o_norm_failed = r_fail;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_qw <= ONE_O && o_qw >= -ONE_O && o_qx <= ONE_O && o_qx >= -ONE_O
                 && o_qy <= ONE_O && o_qy >= -ONE_O && o_qz <= ONE_O && o_qz >= -ONE_O))
        else $error("quaternion word outside the unit range");

    // With a positive trace the scalar part is the leading, non-negative component.
    a_trace_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_branch == rmq_pkg::BR_TRACE) |-> !o_qw[31])
        else $error("negative scalar part on the trace branch");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for rotation_matrix_to_quaternion_top: directed matrices, then random ones.
// Results are compared with given words or a bit-exact predictor. Depends on rmq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC = 30;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint QMAX = 64'sd2147483647;
    localparam int N_RANDOM = 930;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        longint m[9];
    } t_matrix;

    typedef struct packed {
        logic signed [31:0] qw, qx, qy, qz;
        rmq_pkg::t_branch   br;
        logic               nf;
    } t_quat;

    typedef struct {
        t_matrix mat;
        bit      typed;
        t_quat   res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] r_in [9];
    logic               o_done;
    logic signed [31:0] o_qw, o_qx, o_qy, o_qz;
    logic [1:0]         o_branch;
    logic               o_norm_failed;

    t_quat  quat_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_r00(r_in[0]), .i_r01(r_in[1]), .i_r02(r_in[2]),
        .i_r10(r_in[3]), .i_r11(r_in[4]), .i_r12(r_in[5]),
        .i_r20(r_in[6]), .i_r21(r_in[7]), .i_r22(r_in[8]),
        .o_done(o_done), .o_qw(o_qw), .o_qx(o_qx), .o_qy(o_qy), .o_qz(o_qz),
        .o_branch(o_branch), .o_norm_failed(o_norm_failed)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Rounded fixed-point quotient, ties away from zero, clamped to the intermediate limit.
    function automatic longint fix_div(longint num, bit [63:0] den);
        bit [63:0] mag;
        bit [63:0] q;
        mag = (num < 0) ? -num : num;
        q = ((mag << FRAC) + (den >> 1)) / den;
        if (q > QMAX) q = QMAX;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic t_quat predict_quat(t_matrix a);
        longint           tr, arg;
        longint           num[4];
        longint           q[4];
        bit [63:0]        root, scale, n2, mg, nrm;
        rmq_pkg::t_branch br;
        t_quat            res;
        tr = a.m[0] + a.m[4] + a.m[8];
        num = '{0, 0, 0, 0};
        if (tr > 0) begin
            br = rmq_pkg::BR_TRACE;
            arg = tr + ONE;
            num[1] = a.m[7] - a.m[5]; num[2] = a.m[2] - a.m[6]; num[3] = a.m[3] - a.m[1];
        end else if (a.m[0] > a.m[4] && a.m[0] > a.m[8]) begin
            br = rmq_pkg::BR_ROW0;
            arg = ONE + a.m[0] - a.m[4] - a.m[8];
            num[0] = a.m[7] - a.m[5]; num[2] = a.m[1] + a.m[3]; num[3] = a.m[2] + a.m[6];
        end else if (a.m[4] > a.m[8]) begin
            br = rmq_pkg::BR_ROW1;
            arg = ONE + a.m[4] - a.m[0] - a.m[8];
            num[0] = a.m[2] - a.m[6]; num[1] = a.m[1] + a.m[3]; num[3] = a.m[5] + a.m[7];
        end else begin
            br = rmq_pkg::BR_ROW2;
            arg = ONE + a.m[8] - a.m[0] - a.m[4];
            num[0] = a.m[3] - a.m[1]; num[1] = a.m[2] + a.m[6]; num[2] = a.m[5] + a.m[7];
        end
        if (arg < 0) arg = 0;
        root = int_sqrt(64'(arg) << FRAC);
        scale = root << 1;
        for (int i = 0; i < 4; i++) begin
            if (i == int'(br)) begin
                mg = (root + 1) >> 1;
                q[i] = (mg > QMAX) ? QMAX : longint'(mg);
            end else if (scale == 0) begin
                q[i] = (num[i] > 0) ? QMAX : ((num[i] < 0) ? -QMAX : 0);
            end else begin
                q[i] = fix_div(num[i], scale);
            end
        end
        n2 = 0;
        for (int i = 0; i < 4; i++) begin
            mg = (q[i] < 0) ? -q[i] : q[i];
            n2 = n2 + mg * mg;
        end
        res.nf = (n2 == 0);
        if (!res.nf) begin
            nrm = int_sqrt(n2);
            for (int i = 0; i < 4; i++) q[i] = fix_div(q[i], nrm);
        end
        res.qw = 32'(sat_one(q[0]));
        res.qx = 32'(sat_one(q[1]));
        res.qy = 32'(sat_one(q[2]));
        res.qz = 32'(sat_one(q[3]));
        res.br = br;
        return res;
    endfunction

    function automatic longint rand_elem();
        return longint'($urandom_range(32'h8000_0000, 0)) - ONE;
    endfunction

    // An element near base, pulled towards zero so it stays in range.
    function automatic longint near(longint base, int spread);
        longint v;
        v = base + longint'($urandom_range(2 * spread, 0)) - spread;
        return sat_one(v);
    endfunction

    // Mostly near signed permutation matrices, some with tied diagonals, the rest raw noise.
    function automatic t_matrix rand_matrix();
        t_matrix a;
        int      perm[3];
        int      kind, spread, j;
        kind = $urandom_range(9, 0);
        spread = 1 << $urandom_range(29, 0);
        if (kind < 3) begin
            for (int i = 0; i < 9; i++) a.m[i] = rand_elem();
        end else if (kind == 3) begin
            for (int i = 0; i < 9; i++) a.m[i] = near(0, spread);
            a.m[4] = a.m[0];
            if ($urandom_range(1, 0)) a.m[8] = a.m[0];
        end else begin
            perm = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
                j = $urandom_range(i, 0);
                {perm[i], perm[j]} = {perm[j], perm[i]};
            end
            for (int i = 0; i < 9; i++) a.m[i] = near(0, spread);
            for (int i = 0; i < 3; i++)
                a.m[3 * i + perm[i]] = near($urandom_range(1, 0) ? ONE : -ONE, spread);
        end
        return a;
    endfunction

    function automatic t_row diag_row(longint d0, longint d1, longint d2, bit typed,
                                      longint ew, longint ex, longint ey, longint ez,
                                      rmq_pkg::t_branch eb);
        t_row r;
        r.mat.m = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
        r.typed = typed;
        r.res = '{32'(ew), 32'(ex), 32'(ey), 32'(ez), eb, 1'b0};
        return r;
    endfunction

    task automatic compare_quat(t_quat got, t_quat want);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d br=%0d nf=%0b",
                         want.qw, want.qx, want.qy, want.qz, want.br, want.nf);
                $display("          got      w=%0d x=%0d y=%0d z=%0d br=%0d nf=%0b",
                         got.qw, got.qx, got.qy, got.qz, got.br, got.nf);
            end
            mismatches++;
        end
    endtask

    // Present one word and hold it until the block takes it, then wait a random gap.
    task automatic send_matrix(t_matrix a, bit typed, t_quat want);
        int gap;
        for (int i = 0; i < 9; i++) r_in[i] <= a.m[i][31:0];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        quat_q.insert(quat_q.size(), typed ? want : predict_quat(a));
        gap = $urandom_range(4, 0);
        if ($urandom_range(7, 0) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Results come as one-cycle strobes and are checked against the oldest queued expectation.
    always @(posedge i_clk) begin
        t_quat got;
        if (o_done) begin
            got = '{o_qw, o_qx, o_qy, o_qz, o_branch, o_norm_failed};
            if (quat_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected result word");
                mismatches++;
            end else begin
                compare_quat(got, quat_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (start && !busy || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_quat  none;
        i_rst_n = 1'b0;
        start = 1'b0;
        for (int i = 0; i < 9; i++) r_in[i] = '0;
        none = '{0, 0, 0, 0, rmq_pkg::BR_TRACE, 1'b0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.insert(rows.size(),
                    diag_row(ONE, ONE, ONE, 1'b1, ONE, 0, 0, 0, rmq_pkg::BR_TRACE));
        rows.insert(rows.size(),
                    diag_row(0, 0, 0, 1'b1, 0, 0, 0, ONE, rmq_pkg::BR_ROW2));
        rows.insert(rows.size(),
                    diag_row(ONE, -ONE, -ONE, 1'b1, 0, ONE, 0, 0, rmq_pkg::BR_ROW0));
        rows.insert(rows.size(),
                    diag_row(-ONE, ONE, -ONE, 1'b1, 0, 0, ONE, 0, rmq_pkg::BR_ROW1));
        rows.insert(rows.size(),
                    diag_row(-ONE, -ONE, ONE, 1'b1, 0, 0, 0, ONE, rmq_pkg::BR_ROW2));
        rows.insert(rows.size(),
                    diag_row(-ONE, -ONE, -ONE, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE));
        rows.insert(rows.size(),
                    diag_row(ONE, ONE, -ONE, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE));
        rows.insert(rows.size(),
                    diag_row(0, 0, -ONE, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE));
        rows.insert(rows.size(),
                    diag_row(-1, 0, 1, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE));
        // Rotations by a quarter turn about each axis, and five matrices built from extreme entries.
        r = diag_row(ONE, 0, 0, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE);
        r.mat.m[5] = -ONE; r.mat.m[7] = ONE; rows.insert(rows.size(), r);
        r = diag_row(0, ONE, 0, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE);
        r.mat.m[2] = ONE; r.mat.m[6] = -ONE; rows.insert(rows.size(), r);
        r = diag_row(0, 0, ONE, 1'b0, 0, 0, 0, 0, rmq_pkg::BR_TRACE);
        r.mat.m[1] = -ONE; r.mat.m[3] = ONE; rows.insert(rows.size(), r);
        r.mat.m = '{-ONE, ONE, ONE, -ONE, -ONE, ONE, ONE, -ONE, -ONE};
        rows.insert(rows.size(), r);
        r.mat.m = '{-ONE, -ONE, -ONE, ONE, -ONE, -ONE, -ONE, ONE, -ONE};
        rows.insert(rows.size(), r);
        r.mat.m = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
        rows.insert(rows.size(), r);
        r.mat.m = '{-ONE, ONE, -ONE, ONE, 0, -ONE, ONE, -ONE, 0};
        rows.insert(rows.size(), r);
        r.mat.m = '{0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, -ONE};
        rows.insert(rows.size(), r);

        foreach (rows[k]) send_matrix(rows[k].mat, rows[k].typed, rows[k].res);
        for (int n = 0; n < N_RANDOM; n++) send_matrix(rand_matrix(), 1'b0, none);
        start <= 1'b0;

        wait (quat_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
